@@ hw/rtl/ladlp_pkg.sv @@
// ladlp_pkg: shared widths, coefficient constants, word types and saturation
// helpers for the stereo ladder lowpass
// no dependencies
`default_nettype none

package ladlp_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int STATE_BITS     = 32;
  localparam int COEF_FRAC_BITS = 16;

  localparam int CUT_W     = 16;
  localparam int FB_W      = 19;
  localparam int COEF_W    = FB_W;
  localparam int CFG_W     = FB_W;
  localparam int CFG_IDX_W = 2;
  localparam int CHANNELS  = 2;

  localparam int PROD_W = STATE_BITS + COEF_W;
  localparam int MRES_W = PROD_W - COEF_FRAC_BITS + 1;
  localparam int SUM_W  = MRES_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = CFG_IDX_W'(1);

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic CH_LEFT    = 1'b0;
  localparam logic CH_RIGHT   = 1'b1;

  localparam longint ONE_Q_L      = longint'(1) << COEF_FRAC_BITS;
  localparam longint CUTOFF_MAX_L = (ONE_Q_L * 999 + 500) / 1000;
  localparam longint LADDER_K_L   = (ONE_Q_L * 35013 + 50000) / 100000;
  localparam longint TAP_C3_L     = (ONE_Q_L * 3 + 5) / 10;
  localparam longint STATE_MAX_L  = (longint'(1) << (STATE_BITS - 1)) - 1;
  localparam longint SAMPLE_MAX_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

  typedef logic [COEF_W-1:0]               coef_t;
  typedef logic signed [STATE_BITS-1:0]    state_t;
  typedef logic signed [MRES_W-1:0]        mres_t;
  typedef logic signed [SUM_W-1:0]         sum_t;
  typedef logic signed [SAMPLE_BITS-1:0]   sample_t;

  localparam logic [CUT_W-1:0] CUTOFF_RESET = CUT_W'(3168);
  localparam logic [CUT_W-1:0] CUTOFF_MAX   = CUT_W'(CUTOFF_MAX_L);
  localparam logic [FB_W-1:0]  FEEDBACK_MAX = FB_W'(ONE_Q_L * 4);
  localparam coef_t            ONE_COEF     = COEF_W'(ONE_Q_L);
  localparam coef_t            TAP_C3       = COEF_W'(TAP_C3_L);
  localparam state_t           LADDER_K     = STATE_BITS'(LADDER_K_L);
  localparam logic [PROD_W:0]  ROUND_HALF   = (PROD_W + 1)'(ONE_Q_L / 2);

  localparam sum_t   SUM_HI    = SUM_W'(STATE_MAX_L);
  localparam sum_t   SUM_LO    = SUM_W'(-STATE_MAX_L - 1);
  localparam state_t STATE_HI  = STATE_BITS'(STATE_MAX_L);
  localparam state_t STATE_LO  = STATE_BITS'(-STATE_MAX_L - 1);
  localparam state_t SMP_HI_S  = STATE_BITS'(SAMPLE_MAX_L);
  localparam state_t SMP_LO_S  = STATE_BITS'(-SAMPLE_MAX_L - 1);
  localparam sample_t SMP_HI   = SAMPLE_BITS'(SAMPLE_MAX_L);
  localparam sample_t SMP_LO   = SAMPLE_BITS'(-SAMPLE_MAX_L - 1);

  typedef struct packed {
    logic    command;
    sample_t left_sample;
    sample_t right_sample;
  } in_word_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_word_t;

  // value handed from one ladder cell to the next
  typedef struct packed {
    logic   vld;
    logic   ch;
    state_t val;
  } tok_t;

  function automatic state_t sat_state(sum_t x);
    state_t r;
    if (x > SUM_HI) begin
      r = STATE_HI;
    end else if (x < SUM_LO) begin
      r = STATE_LO;
    end else begin
      r = STATE_BITS'(x);
    end
    return r;
  endfunction

  function automatic sample_t sat_sample(state_t x);
    sample_t r;
    if (x > SMP_HI_S) begin
      r = SMP_HI;
    end else if (x < SMP_LO_S) begin
      r = SMP_LO;
    end else begin
      r = SAMPLE_BITS'(x);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ladlp_mul.sv @@
// ladlp_mul: two-stage signed value times unsigned coefficient, rounded half
// away from zero after the fraction shift
// depends on ladlp_pkg
`default_nettype none

module ladlp_mul (
  input  logic              clk,
  input  ladlp_pkg::state_t a,
  input  ladlp_pkg::coef_t  c,
  output ladlp_pkg::mres_t  p
);
  import ladlp_pkg::*;

  logic [STATE_BITS-1:0] mag;
  logic [PROD_W-1:0]     prod_r;
  logic                  neg_r;
  logic [PROD_W:0]       rnd;
  logic [MRES_W-1:0]     mag_q;
  mres_t                 p_r;

  assign mag   = a[STATE_BITS-1] ? STATE_BITS'(-a) : STATE_BITS'(a);
  assign rnd   = (PROD_W + 1)'(prod_r) + ROUND_HALF;
  assign mag_q = rnd[PROD_W:COEF_FRAC_BITS];

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mag) * PROD_W'(c);
    neg_r  <= a[STATE_BITS-1];
    p_r    <= neg_r ? -mres_t'(mag_q) : mres_t'(mag_q);
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ hw/rtl/ladlp_cell.sv @@
// ladlp_cell: one one-pole ladder stage for both channels, passing each word
// through d1_r, d2_r and out_r, holding that stage's previous input and output
// depends on ladlp_pkg, ladlp_mul
`default_nettype none

module ladlp_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  ladlp_pkg::coef_t omf,
  input  ladlp_pkg::tok_t  tok_in,
  output ladlp_pkg::tok_t  tok_out
);
  import ladlp_pkg::*;

  state_t pin_r  [CHANNELS];
  state_t pout_r [CHANNELS];
  tok_t   d1_r;
  tok_t   d2_r;
  tok_t   out_r;
  mres_t  p_in;
  mres_t  p_out;
  state_t o_nxt;

  ladlp_mul u_mul_in (
    .clk (clk),
    .a   (pin_r[tok_in.ch]),
    .c   (TAP_C3),
    .p   (p_in)
  );

  ladlp_mul u_mul_out (
    .clk (clk),
    .a   (pout_r[tok_in.ch]),
    .c   (omf),
    .p   (p_out)
  );

  assign o_nxt = sat_state(sum_t'(d2_r.val) + sum_t'(p_in) + sum_t'(p_out));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r  <= '0;
      d2_r  <= '0;
      out_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pin_r[i]  <= '0;
        pout_r[i] <= '0;
      end
    end else begin
      d1_r      <= tok_in;
      d2_r      <= d1_r;
      out_r.vld <= d2_r.vld;
      out_r.ch  <= d2_r.ch;
      out_r.val <= o_nxt;
      if (clr) begin
        for (int i = 0; i < CHANNELS; i++) begin
          pin_r[i]  <= '0;
          pout_r[i] <= '0;
        end
      end else if (d2_r.vld) begin
        pin_r[d2_r.ch]  <= d2_r.val;
        pout_r[d2_r.ch] <= o_nxt;
      end
    end
  end

  assign tok_out = out_r;

endmodule

`default_nettype wire

@@ hw/rtl/stereo_four_pole_ladder_lowpass.sv @@
// stereo_four_pole_ladder_lowpass: top level with coefficient sequencer,
// feedback front end, chain of four ladder cells and output register
// depends on ladlp_pkg, ladlp_mul, ladlp_cell
`default_nettype none

// A filter word (command 0) returns one result word, and the input takes the
// next word only after that result has left the holding register, which
// needs the output register to be empty or read. The sequencer steps S_F2 to
// S_TOKR run on one shared multiplier that forms f^2, f^4, the input gain and
// both feedback products; the left and right samples then pass, left first,
// through four ladder cells. A clear word (command 1) zeroes all filter state
// in its own accept cycle, gives no result, and the next word may follow at
// once. Cutoff above 0.999 and feedback above 4.0 are clamped. A result
// waits in a holding register and then in the output register, so one
// finished word may sit unread while the next one is taken in.
module stereo_four_pole_ladder_lowpass (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ladlp_pkg::in_word_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output ladlp_pkg::out_word_t                   out_data,
  input  logic                                   cfg_wr_en,
  input  logic [ladlp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ladlp_pkg::CFG_W-1:0]            cfg_wdata
);
  import ladlp_pkg::*;

  localparam int STEP_W = 5;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [STEP_W-1:0] S_F2   = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_FBL  = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_F4   = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_FBR  = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_G    = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_VR   = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_GL   = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_GR   = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_TOKL = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_TOKR = STEP_W'(9);
  localparam int ACCEPT_TO_HOLD = 23;

  logic               state_r;
  logic [STEP_W-1:0]  step_r;
  logic [CUT_W-1:0]   cut_r;
  logic [FB_W-1:0]    fbk_r;
  logic [CUT_W-1:0]   f_r;
  coef_t              fb_r;
  coef_t              omf_r;
  coef_t              g_r;
  sample_t            xl_r;
  sample_t            xr_r;
  state_t             vl_r;
  state_t             vr_r;
  state_t             yl_r;
  state_t             yr_r;
  logic               res_v_r;
  out_word_t          res_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic               in_acc;
  logic               clr;
  state_t             ma;
  coef_t              mc;
  mres_t              mres;
  tok_t               tok [5];
  logic               done;

  assign in_ready = (state_r == ST_IDLE) && !res_v_r;
  assign in_acc   = in_valid && in_ready;
  assign clr      = in_acc && (in_data.command == CMD_CLEAR);

  always_comb begin
    ma = '0;
    mc = '0;
    unique case (step_r)
      S_F2: begin
        ma = STATE_BITS'(f_r);
        mc = COEF_W'(f_r);
      end
      S_FBL: begin
        ma = yl_r;
        mc = fb_r;
      end
      S_F4: begin
        ma = STATE_BITS'(mres);
        mc = COEF_W'(mres);
      end
      S_FBR: begin
        ma = yr_r;
        mc = fb_r;
      end
      S_G: begin
        ma = LADDER_K;
        mc = COEF_W'(mres);
      end
      S_GL: begin
        ma = vl_r;
        mc = COEF_W'(mres);
      end
      S_GR: begin
        ma = vr_r;
        mc = g_r;
      end
      default: begin
        ma = '0;
        mc = '0;
      end
    endcase
  end

  ladlp_mul u_mul (
    .clk (clk),
    .a   (ma),
    .c   (mc),
    .p   (mres)
  );

  assign tok[0].vld = (state_r == ST_RUN) && ((step_r == S_TOKL) || (step_r == S_TOKR));
  assign tok[0].ch  = (step_r == S_TOKR) ? CH_RIGHT : CH_LEFT;
  assign tok[0].val = sat_state(sum_t'(mres));

  for (genvar k = 0; k < 4; k++) begin : g_cell
    ladlp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (clr),
      .omf     (omf_r),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign done = tok[4].vld && (tok[4].ch == CH_RIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cut_r       <= CUTOFF_RESET;
      fbk_r       <= '0;
      yl_r        <= '0;
      yr_r        <= '0;
      res_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_CUTOFF:   cut_r <= cfg_wdata[CUT_W-1:0];
          CFG_FEEDBACK: fbk_r <= cfg_wdata[FB_W-1:0];
          default: ;
        endcase
      end

      if (clr) begin
        yl_r <= '0;
        yr_r <= '0;
      end else if (tok[4].vld) begin
        if (tok[4].ch == CH_RIGHT) begin
          yr_r <= tok[4].val;
        end else begin
          yl_r <= tok[4].val;
        end
      end

      priority if (in_acc && (in_data.command == CMD_FILTER)) begin
        state_r <= ST_RUN;
        step_r  <= '0;
      end else if (done) begin
        state_r <= ST_IDLE;
      end else if (state_r == ST_RUN) begin
        step_r <= step_r + 1'b1;
      end

      if (done) begin
        res_v_r <= 1'b1;
      end else if (res_v_r && (!out_valid_r || out_ready)) begin
        res_v_r <= 1'b0;
      end

      if (res_v_r && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_r   <= (cut_r > CUTOFF_MAX) ? CUTOFF_MAX : cut_r;
      fb_r  <= (fbk_r > FEEDBACK_MAX) ? COEF_W'(FEEDBACK_MAX) : COEF_W'(fbk_r);
      omf_r <= ONE_COEF - COEF_W'((cut_r > CUTOFF_MAX) ? CUTOFF_MAX : cut_r);
      xl_r  <= in_data.left_sample;
      xr_r  <= in_data.right_sample;
    end
    if (step_r == S_FBR) begin
      vl_r <= sat_state(sum_t'(xl_r) - sum_t'(mres));
    end
    if (step_r == S_VR) begin
      vr_r <= sat_state(sum_t'(xr_r) - sum_t'(mres));
    end
    if (step_r == S_GL) begin
      g_r <= COEF_W'(mres);
    end
    if (done) begin
      res_r.left_out  <= sat_sample(yl_r);
      res_r.right_out <= sat_sample(tok[4].val);
    end
    if (res_v_r && (!out_valid_r || out_ready)) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cell_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok[4].vld |-> (state_r == ST_RUN))
    else $error("ladder word left the last cell outside a run");

  a_hold_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && !out_valid_r) |=> !res_v_r)
    else $error("held result not moved to an empty output register");

  a_filter_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.command == CMD_FILTER)) |-> ##ACCEPT_TO_HOLD res_v_r)
    else $error("filter word did not produce a result on schedule");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !in_ready)
    else $error("input ready while a word is in the ladder");

endmodule

`default_nettype wire
